### rtl/core/oiir_pkg.sv
// Shared types and constants for the op-amp integrator recurrence block.
// Used by oiir_ctrl, oiir_dp and opamp_integrator_iir_step; no dependencies.
package oiir_pkg;

    // Default data format: signed Q8.24
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    // Coefficient registers
    localparam int COEF_W    = 32;
    localparam int NUM_COEF  = 7;
    localparam int CFG_IDX_W = 3;

    // Coefficient / term codes (register index and MAC term order)
    localparam logic [CFG_IDX_W-1:0] K_NODE_PREV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] K_NODE_IN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] K_NODE_OUT_PREV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] K_NODE_IN_PREV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] K_OUT_NODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] K_OUT_NODE_PREV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] K_OUT_IN        = 3'd6;

    // MAC step counter: two partial products per term
    localparam int                STEP_W     = 4;
    localparam logic [STEP_W-1:0] STEP_NODE_LAST = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OUT_LAST  = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_NODE,
        ST_DRAIN_NODE,
        ST_RND_NODE,
        ST_MAC_OUT,
        ST_DRAIN_OUT,
        ST_RND_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic              round_node;
        logic              out_write;
        logic [STEP_W-1:0] step;
    } t_cmd;

endpackage

### rtl/core/opamp_integrator_iir_step.sv
// Finite-gain op-amp integrator recurrence, one output sample per input.
// Input channel: i_valid / o_stall with i_vin; a transaction is taken at an
// edge with i_valid high and o_stall low. Output channel: o_valid / i_stall
// with o_vout and o_saturated, held stable while i_stall is high.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
// write the seven Q8.24 coefficients; o_cfg_ready is always high and writes
// to index 7 are dropped. Write coefficients only while the block is idle.
// One item is in flight at a time; a new sample is taken the cycle after the
// result enters the output register and o_valid rises. The sequence uses one
// shared 32 x (DATA_WIDTH - DATA_WIDTH/2 + 1) multiplier doing two partial
// products for each of the seven terms, plus a drain state and a round/saturate
// state for each sum. If the output is still held by i_stall when the next
// result is ready, the block waits in its last step and keeps o_stall high.
// Reset (synchronous, active low) clears coefficients, node, output and input
// history to zero and empties the output register.
module opamp_integrator_iir_step #(
    parameter int DATA_WIDTH = oiir_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = oiir_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [DATA_WIDTH-1:0]   i_vin,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [DATA_WIDTH-1:0]   o_vout,
    output logic                           o_saturated,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [oiir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [oiir_pkg::COEF_W-1:0]    i_cfg_data
);
    import oiir_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    oiir_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    oiir_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_vin       (i_vin),
        .o_vout      (o_vout),
        .o_saturated (o_saturated)
    );

`ifndef SYNTH
    // A new result never overwrites one the receiver is still holding
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_write |-> !(o_valid && i_stall))
        else $error("result written while output held");

    // No input is taken while the multiplier is busy
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_en |-> o_stall)
        else $error("input not stalled during MAC");

    // An accepted sample starts the MAC sequence on the next cycle
    a_start_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (cmd.mul_en && cmd.step == '0))
        else $error("MAC did not start after input transaction");

    // Node rounding is always followed by the output MAC phase
    a_node_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.round_node |=> (cmd.mul_en && !cmd.out_write))
        else $error("output MAC did not follow node rounding");
`endif

endmodule

### rtl/core/oiir_ctrl.sv
// Sequencer for the integrator recurrence: handshakes and MAC step control.
// Depends on oiir_pkg; drives the command struct of oiir_dp.
module oiir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output oiir_pkg::t_cmd o_cmd
);
    import oiir_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_vld, n_out_vld;
    logic              out_free;

    // Output register can take a new transaction when empty or draining now
    assign out_free = !r_out_vld || !i_stall;

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MAC_NODE;
                    n_step  = '0;
                end
            end
            ST_MAC_NODE: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_NODE_LAST) begin
                    n_state = ST_DRAIN_NODE;
                end
            end
            ST_DRAIN_NODE: n_state = ST_RND_NODE;
            ST_RND_NODE:   n_state = ST_MAC_OUT;
            ST_MAC_OUT: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_OUT_LAST) begin
                    n_state = ST_DRAIN_OUT;
                end
            end
            ST_DRAIN_OUT:  n_state = ST_RND_OUT;
            ST_RND_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.step       = r_step;
        o_cmd.load       = (r_state == ST_IDLE) && i_valid;
        o_cmd.mul_en     = (r_state == ST_MAC_NODE) || (r_state == ST_MAC_OUT);
        o_cmd.round_node = (r_state == ST_RND_NODE);
        o_cmd.out_write  = (r_state == ST_RND_OUT) && out_free;
        o_stall          = (r_state != ST_IDLE);
    end

    // Set output valid on write, drop it when the transaction is taken
    assign n_out_vld = o_cmd.out_write || (r_out_vld && i_stall);
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

### rtl/core/oiir_dp.sv
// Datapath: coefficient registers, recurrence state, shared split multiplier,
// accumulator and round/saturate unit. Depends on oiir_pkg.
module oiir_dp #(
    parameter int DATA_WIDTH = oiir_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = oiir_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oiir_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_we,
    input  logic [oiir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [oiir_pkg::COEF_W-1:0]       i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0]      i_vin,
    output logic signed [DATA_WIDTH-1:0]      o_vout,
    output logic                              o_saturated
);
    import oiir_pkg::*;

    // Data is split into an unsigned low half and a signed high half
    localparam int LO_W   = DATA_WIDTH / 2;
    localparam int HI_W   = DATA_WIDTH - LO_W;
    localparam int PART_W = HI_W + 1;
    localparam int PROD_W = COEF_W + PART_W;
    localparam int ACC_A  = DATA_WIDTH + COEF_W + 3;
    localparam int ACC_B  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int SH_W   = ACC_W - FRAC_BITS;

    localparam logic [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [COEF_W-1:0]     r_coef [NUM_COEF];
    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [DATA_WIDTH-1:0] r_node_prev;
    logic signed [DATA_WIDTH-1:0] r_out_prev;
    logic signed [DATA_WIDTH-1:0] r_in_prev;
    logic signed [DATA_WIDTH-1:0] r_node;
    logic signed [DATA_WIDTH-1:0] r_vout;
    logic                         r_sat;
    logic                         r_clip;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_prod_vld;
    logic                         r_prod_hi;

    logic [CFG_IDX_W-1:0]         term;
    logic signed [COEF_W-1:0]     coef_sel;
    logic signed [DATA_WIDTH-1:0] data_sel;
    logic signed [PART_W-1:0]     part_op;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      addend;
    logic signed [ACC_W-1:0]      rnd_sum;
    logic [SH_W-1:0]              rnd_sh;
    logic [SH_W-DATA_WIDTH:0]     rnd_top;
    logic                         fits;
    logic [DATA_WIDTH-1:0]        sat_val;

    // Select coefficient and data word for the current term
    assign term = i_cmd.step[STEP_W-1:1];

    always_comb begin
        unique case (term)
            K_NODE_PREV: begin
                coef_sel = r_coef[K_NODE_PREV];
                data_sel = r_node_prev;
            end
            K_NODE_IN: begin
                coef_sel = r_coef[K_NODE_IN];
                data_sel = r_x;
            end
            K_NODE_OUT_PREV: begin
                coef_sel = r_coef[K_NODE_OUT_PREV];
                data_sel = r_out_prev;
            end
            K_NODE_IN_PREV: begin
                coef_sel = r_coef[K_NODE_IN_PREV];
                data_sel = r_in_prev;
            end
            K_OUT_NODE: begin
                coef_sel = r_coef[K_OUT_NODE];
                data_sel = r_node;
            end
            K_OUT_NODE_PREV: begin
                coef_sel = r_coef[K_OUT_NODE_PREV];
                data_sel = r_node_prev;
            end
            K_OUT_IN: begin
                coef_sel = r_coef[K_OUT_IN];
                data_sel = r_x;
            end
            default: begin
                coef_sel = '0;
                data_sel = '0;
            end
        endcase
    end

    // Odd steps take the signed high half, even steps the unsigned low half
    assign part_op = i_cmd.step[0]
        ? $signed({data_sel[DATA_WIDTH-1], data_sel[DATA_WIDTH-1:LO_W]})
        : $signed({{(PART_W-LO_W){1'b0}}, data_sel[LO_W-1:0]});

    assign prod = coef_sel * part_op;

    // Align the registered partial product
    always_comb begin
        addend = $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
        if (r_prod_hi) begin
            addend = addend <<< LO_W;
        end
    end

    // Round half up, drop fraction bits, clamp to the data range
    assign rnd_sum = r_acc + $signed(HALF);
    assign rnd_sh  = rnd_sum[ACC_W-1:FRAC_BITS];
    assign rnd_top = rnd_sh[SH_W-1:DATA_WIDTH-1];
    assign fits    = (&rnd_top) || !(|rnd_top);
    assign sat_val = fits ? rnd_sh[DATA_WIDTH-1:0]
                          : (rnd_sh[SH_W-1] ? SAT_MIN : SAT_MAX);

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_COEF))) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Multiplier stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= prod;
            r_prod_hi <= i_cmd.step[0];
        end
    end

    // Accumulator: clear at start of each sum, add each partial product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.round_node) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + addend;
        end
    end

    // Latch input sample and node value; track clipping for this item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_vin;
        end
        if (i_cmd.round_node) begin
            r_node <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else if (i_cmd.load) begin
            r_clip <= 1'b0;
        end else if (i_cmd.round_node) begin
            r_clip <= r_clip | !fits;
        end
    end

    // Advance recurrence state when the result is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_prev <= '0;
            r_out_prev  <= '0;
            r_in_prev   <= '0;
        end else if (i_cmd.out_write) begin
            r_node_prev <= r_node;
            r_out_prev  <= sat_val;
            r_in_prev   <= r_x;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_vout <= sat_val;
            r_sat  <= r_clip | !fits;
        end
    end

    assign o_vout      = r_vout;
    assign o_saturated = r_sat;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for opamp_integrator_iir_step (op-amp integrator recurrence).
// Depends on oiir_pkg and the block's RTL; predicts every output sample in a scoreboard class.
module testbench;
    import oiir_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int FW         = FRAC_BITS_DEF;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS  = 100;
    localparam int PRINT_CAP    = 100;

    typedef logic signed [DW-1:0]     t_data;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [71:0]       t_acc;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    typedef struct packed {
        t_data vout;
        logic  saturated;
    } t_sample_result;

    typedef enum int {COEF_SMALL, COEF_INTEG, COEF_FULL, COEF_EDGE} t_coef_mix;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} t_rx_mode;

    localparam t_data    DATA_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam t_data    DATA_MIN   = {1'b1, {(DW-1){1'b0}}};
    localparam t_data    FIX_ONE    = t_data'(1) <<< FW;
    localparam t_coef    COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef    COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam t_acc     ACC_MAX    = DATA_MAX;
    localparam t_acc     ACC_MIN    = DATA_MIN;
    localparam t_acc     ROUND_HALF = t_acc'(1) <<< (FW - 1);
    // first index past the coefficient bank; writes there must be dropped
    localparam t_cfg_idx K_UNUSED   = t_cfg_idx'(NUM_COEF);

    // Predict the recurrence and hold expected output samples in order
    class iir_scoreboard;
        t_coef          coef [NUM_COEF];
        t_data          node_hist;
        t_data          out_hist;
        t_data          in_hist;
        t_sample_result expected_q [$];

        function new();
            foreach (coef[i]) coef[i] = '0;
            node_hist = '0;
            out_hist  = '0;
            in_hist   = '0;
        endfunction

        function void write_coef(t_cfg_idx idx, logic [COEF_W-1:0] wdata);
            if (idx < NUM_COEF) coef[idx] = wdata;
        endfunction

        function t_acc mul(t_coef k, t_data v);
            t_acc wk;
            t_acc wv;
            wk = k;
            wv = v;
            return wk * wv;
        endfunction

        // Round half up at the fraction point, then clip to the data range
        function t_data round_clamp(t_acc acc, inout bit clipped);
            t_acc shifted;
            shifted = (acc + ROUND_HALF) >>> FW;
            if (shifted > ACC_MAX) begin
                clipped = 1'b1;
                return DATA_MAX;
            end
            if (shifted < ACC_MIN) begin
                clipped = 1'b1;
                return DATA_MIN;
            end
            return shifted[DW-1:0];
        endfunction

        function void note_sample(t_data vin);
            t_acc           acc_sum;
            t_data          node;
            t_data          vout;
            bit             clipped;
            t_sample_result res;
            clipped = 1'b0;
            acc_sum = mul(coef[K_NODE_PREV], node_hist) + mul(coef[K_NODE_IN], vin)
                    + mul(coef[K_NODE_OUT_PREV], out_hist)
                    + mul(coef[K_NODE_IN_PREV], in_hist);
            node = round_clamp(acc_sum, clipped);
            acc_sum = mul(coef[K_OUT_NODE], node) + mul(coef[K_OUT_NODE_PREV], node_hist)
                    + mul(coef[K_OUT_IN], vin);
            vout = round_clamp(acc_sum, clipped);
            node_hist = node;
            out_hist  = vout;
            in_hist   = vin;
            res.vout      = vout;
            res.saturated = clipped;
            expected_q.push_back(res);
        endfunction

        // Return an empty string on a match, else what went wrong
        function string check_result(t_data vout, logic saturated);
            t_sample_result exp_res;
            string          msg;
            if (expected_q.size() == 0) begin
                return $sformatf("unexpected sample vout=%0d saturated=%0b", vout, saturated);
            end
            exp_res = expected_q.pop_front();
            msg = "";
            if (vout !== exp_res.vout)
                msg = {msg, $sformatf(" vout got %0d want %0d", vout, exp_res.vout)};
            if (saturated !== exp_res.saturated)
                msg = {msg, $sformatf(" saturated got %0b want %0b", saturated,
                                      exp_res.saturated)};
            return msg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_data                 i_vin       = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_data                 o_vout;
    logic                  o_saturated;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = '0;
    logic [COEF_W-1:0]     i_cfg_data  = '0;

    iir_scoreboard sb = new();
    int            errors = 0;
    int            quiet_cycles = 0;
    string         mismatch;
    t_rx_mode      rx_mode = RX_OPEN;
    int            rx_left = 0;

    opamp_integrator_iir_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_vin       (i_vin),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_vout      (o_vout),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("%0t: mismatch:%s", $time, msg);
    endtask

    // Track every transaction on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_coef(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) sb.note_sample(i_vin);
            if (o_valid && !i_stall) begin
                mismatch = sb.check_result(o_vout, o_saturated);
                if (mismatch != "") report_mismatch(mismatch);
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure: switch between stall densities every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(RX_OPEN, RX_HEAVY));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HALF:  i_stall <= ($urandom_range(0, 1) == 0);
            default:  i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [COEF_W-1:0] wdata);
        i_cfg_index <= idx;
        i_cfg_data  <= wdata;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_coefs(input t_coef k [NUM_COEF]);
        write_reg(K_UNUSED, $urandom());
        for (int i = 0; i < NUM_COEF; i++) write_reg(t_cfg_idx'(i), k[i]);
        i_cfg_valid <= 1'b0;
    endtask

    // Present one sample and hold it until taken; returns at a falling edge
    task automatic send_sample(input t_data v);
        i_vin   <= v;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain all outstanding samples so the block is idle for the next write
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic directed_phase(input t_coef k [NUM_COEF], input t_data seq [$]);
        program_coefs(k);
        foreach (seq[i]) send_sample(seq[i]);
        settle();
    endtask

    function automatic t_coef rand_coef(t_coef_mix mix);
        case (mix)
            COEF_SMALL: return int'($urandom_range(0, 1 << FW)) - (1 << (FW - 1));
            COEF_FULL:  return $urandom();
            COEF_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    3:       return FIX_ONE;
                    default: return -FIX_ONE;
                endcase
            end
            default:    return int'($urandom_range(0, 1 << (FW - 2))) - (1 << (FW - 3));
        endcase
    endfunction

    function automatic t_data rand_sample();
        case ($urandom_range(0, 9))
            6, 7: return $urandom();
            8: begin
                case ($urandom_range(0, 4))
                    0:       return DATA_MAX;
                    1:       return DATA_MIN;
                    2:       return '0;
                    3:       return t_data'(1);
                    default: return t_data'(-1);
                endcase
            end
            default: return int'($urandom_range(0, 1 << (FW + 2))) - (1 << (FW + 1));
        endcase
    endfunction

    task automatic random_phase(input t_coef_mix mix, input int n_items);
        t_coef k [NUM_COEF];
        int    sent;
        int    burst;
        foreach (k[i]) k[i] = rand_coef(mix);
        // leaky integrator: node feedback at or just under one, node passed to output
        if (mix == COEF_INTEG) begin
            k[K_NODE_PREV] = FIX_ONE - t_coef'($urandom_range(0, 1 << (FW - 4)));
            k[K_OUT_NODE]  = FIX_ONE;
        end
        program_coefs(k);
        sent = 0;
        while (sent < n_items) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            while (burst > 0 && sent < n_items) begin
                send_sample(rand_sample());
                burst--;
                sent++;
            end
            // hold valid across some burst boundaries, drop it for a gap otherwise
            if ($urandom_range(0, 3) != 0 && sent < n_items) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
        settle();
    endtask

    initial begin
        t_coef k [NUM_COEF];
        t_data seq [$];

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all weights zero: output stays zero whatever the input
        k = '{default: '0};
        seq = '{DATA_MAX, DATA_MIN, '0};
        directed_phase(k, seq);

        // every term active, driven into node and output clipping
        k = '{FIX_ONE, FIX_ONE / 4, -(FIX_ONE / 8), FIX_ONE / 4,
              FIX_ONE, -(FIX_ONE / 2), FIX_ONE / 2};
        seq = '{t_data'(1), t_data'(-1), FIX_ONE / 2, DATA_MAX, DATA_MAX, DATA_MAX,
                DATA_MIN, DATA_MIN, DATA_MIN, '0};
        directed_phase(k, seq);

        // extreme weights
        k = '{default: COEF_MAX};
        seq = '{t_data'(1), t_data'(-1), DATA_MIN};
        directed_phase(k, seq);
        k = '{default: COEF_MIN};
        seq = '{t_data'(1), DATA_MAX, DATA_MIN};
        directed_phase(k, seq);

        // rounding of exact halves goes toward plus infinity
        k = '{default: '0};
        k[K_OUT_IN] = FIX_ONE / 2;
        seq = '{t_data'(1), t_data'(-1), t_data'(3), t_data'(-3)};
        directed_phase(k, seq);

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(t_coef_mix'(p % 4), PHASE_ITEMS);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### sim.f
rtl/core/oiir_pkg.sv
rtl/core/oiir_ctrl.sv
rtl/core/oiir_dp.sv
rtl/core/opamp_integrator_iir_step.sv
dv/testbench.sv
